>>> hdl/pft_pkg.sv
// shared types and codes for the priority flood trapped water block
`timescale 1ns / 1ps
package pft_pkg;

    // configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam logic [6:0] DIM_RESET = 7'd64;

    // neighbor directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLR,
        CMD_SEED_RD,
        CMD_SEED_PUSH,
        CMD_SEED_NX,
        CMD_PU_BEGIN,
        CMD_PU_RD,
        CMD_PU_MOVE,
        CMD_PU_WR,
        CMD_PO_RD,
        CMD_PO_LAT,
        CMD_PO_RD2,
        CMD_PO_MOVE,
        CMD_PO_WR,
        CMD_NB_BASE,
        CMD_NB_RD,
        CMD_NB_VISIT,
        CMD_NB_NX,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic seed_last;
        logic heap_full;
        logic heap_empty;
        logic pu_root;
        logic pu_stop;
        logic po_leaf;
        logic po_stop;
        logic dir_ok;
        logic dir_last;
        logic nb_visited;
    } stat_t;

endpackage

>>> hdl/pft_dp.sv
// datapath: height store, visited map, heap memory and flood arithmetic
`timescale 1ns / 1ps
module pft_dp #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  pft_pkg::cmd_t    cmd,
    output pft_pkg::stat_t   stat,
    input  logic [15:0]      in_height,
    input  logic             in_last,
    input  logic             cfg_valid,
    input  logic             cfg_index,
    input  logic [6:0]       cfg_data,
    output logic [31:0]      out_volume
);
    import pft_pkg::*;

    localparam int HB     = HEIGHT_BITS;
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int CA_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CN_W   = $clog2(CELLS + 1) + 1;
    localparam int HDEPTH = 2 * CELLS;
    localparam int HA_W   = $clog2(HDEPTH);
    localparam int HC_W   = $clog2(HDEPTH + 1);
    localparam int HL_W   = HA_W + 2;
    localparam int EW     = HB + ROW_W + COL_W;

    // configuration
    logic [6:0] rows_reg, cols_reg;
    logic [ROW_W-1:0] rows_c;
    logic [COL_W-1:0] cols_c;
    logic [CN_W-1:0]  used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_RESET;
            cols_reg <= DIM_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NUM_ROWS: rows_reg <= cfg_data;
                REG_NUM_COLS: cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (rows_reg == 7'd0) rows_c = ROW_W'(1);
        else if (32'(rows_reg) > MAX_ROWS) rows_c = ROW_W'(MAX_ROWS);
        else rows_c = ROW_W'(rows_reg);
        if (cols_reg == 7'd0) cols_c = COL_W'(1);
        else if (32'(cols_reg) > MAX_COLS) cols_c = COL_W'(MAX_COLS);
        else cols_c = COL_W'(cols_reg);
        used = CN_W'(CN_W'(rows_c) * CN_W'(cols_c));
    end

    // memories
    logic [HB-0-1:0] hmem [CELLS];
    logic            vmem [CELLS];
    logic [EW-1:0]   heap [HDEPTH];

    logic [HB-1:0]   h_rd_reg;
    logic            v_rd_reg;
    logic [EW-1:0]   rda_reg, rdb_reg;

    // working registers
    logic [CN_W-1:0]  lp_reg;
    logic [CA_W-1:0]  cnt_reg;
    logic [ROW_W-1:0] sr_reg;
    logic [COL_W-1:0] sc_reg;
    logic [CA_W-1:0]  saddr_reg;
    logic [HC_W-1:0]  count_reg;
    logic [HA_W-1:0]  i_reg;
    logic [EW-1:0]    item_reg, cur_reg, last_reg;
    logic [CA_W-1:0]  cur_addr_reg;
    logic [1:0]       dir_reg;
    logic [31:0]      total_reg;
    logic [31:0]      out_reg;

    // entry fields
    logic [HB-1:0]    cur_lev, last_lev, item_lev, rda_lev, rdb_lev, hm_lev;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    assign cur_lev  = cur_reg[EW-1 -: HB];
    assign last_lev = last_reg[EW-1 -: HB];
    assign item_lev = item_reg[EW-1 -: HB];
    assign rda_lev  = rda_reg[EW-1 -: HB];
    assign rdb_lev  = rdb_reg[EW-1 -: HB];
    assign cur_row  = cur_reg[ROW_W+COL_W-1 -: ROW_W];
    assign cur_col  = cur_reg[COL_W-1:0];

    // heap index arithmetic
    logic [HA_W-1:0] parent;
    logic [HL_W-1:0] lch, rch;
    logic            pick_r;
    logic [EW-1:0]   hm;
    logic [HA_W-1:0] m_idx;
    logic [HA_W-1:0] last_idx;
    assign parent   = HA_W'((i_reg - HA_W'(1)) >> 1);
    assign lch      = (HL_W'(i_reg) << 1) + HL_W'(1);
    assign rch      = lch + HL_W'(1);
    assign pick_r   = (rch < HL_W'(count_reg)) && (rdb_lev < rda_lev);
    assign hm       = pick_r ? rdb_reg : rda_reg;
    assign hm_lev   = hm[EW-1 -: HB];
    assign m_idx    = pick_r ? rch[HA_W-1:0] : lch[HA_W-1:0];
    assign last_idx = HA_W'(count_reg - HC_W'(1));

    // neighbor selection
    logic [CN_W-1:0]  na_full;
    logic [CA_W-1:0]  na;
    logic [ROW_W-1:0] nrow;
    logic [COL_W-1:0] ncol;
    logic             dir_ok;
    always_comb begin
        unique case (dir_reg)
            DIR_UP: begin
                dir_ok  = cur_row != '0;
                na_full = CN_W'(cur_addr_reg) - CN_W'(cols_c);
                nrow    = cur_row - ROW_W'(1);
                ncol    = cur_col;
            end
            DIR_DOWN: begin
                dir_ok  = (ROW_W+1)'(cur_row) + (ROW_W+1)'(1) < (ROW_W+1)'(rows_c);
                na_full = CN_W'(cur_addr_reg) + CN_W'(cols_c);
                nrow    = cur_row + ROW_W'(1);
                ncol    = cur_col;
            end
            DIR_LEFT: begin
                dir_ok  = cur_col != '0;
                na_full = CN_W'(cur_addr_reg) - CN_W'(1);
                nrow    = cur_row;
                ncol    = cur_col - COL_W'(1);
            end
            default: begin
                dir_ok  = (COL_W+1)'(cur_col) + (COL_W+1)'(1) < (COL_W+1)'(cols_c);
                na_full = CN_W'(cur_addr_reg) + CN_W'(1);
                nrow    = cur_row;
                ncol    = cur_col + COL_W'(1);
            end
        endcase
        na = na_full[CA_W-1:0];
    end

    // memory ports
    logic            h_we;
    logic [HB-1:0]   h_wdata;
    logic [CA_W-1:0] h_raddr;
    logic            v_we, v_wdata;
    logic [CA_W-1:0] v_waddr;
    logic            hp_we;
    logic [HA_W-1:0] hp_waddr, hp_addr_a, hp_addr_b;
    logic [EW-1:0]   hp_wdata;

    assign h_we    = (cmd == CMD_LOAD) && (lp_reg < used);
    assign h_wdata = HB'(in_height);
    assign h_raddr = (cmd == CMD_SEED_RD) ? saddr_reg : na;

    always_comb begin
        v_we    = 1'b0;
        v_wdata = 1'b0;
        v_waddr = na;
        hp_we    = 1'b0;
        hp_waddr = i_reg;
        hp_wdata = item_reg;
        hp_addr_a = '0;
        hp_addr_b = last_idx;
        unique case (cmd)
            CMD_CLR: begin
                v_we    = 1'b1;
                v_waddr = cnt_reg;
            end
            CMD_SEED_RD: begin
                v_we    = 1'b1;
                v_wdata = 1'b1;
                v_waddr = saddr_reg;
            end
            CMD_NB_VISIT: begin
                v_we    = 1'b1;
                v_wdata = 1'b1;
            end
            CMD_PU_RD: hp_addr_a = parent;
            CMD_PU_MOVE: begin
                hp_we    = 1'b1;
                hp_wdata = rda_reg;
            end
            CMD_PU_WR: hp_we = 1'b1;
            CMD_PO_RD2: begin
                hp_addr_a = lch[HA_W-1:0];
                hp_addr_b = rch[HA_W-1:0];
            end
            CMD_PO_MOVE: begin
                hp_we    = 1'b1;
                hp_wdata = hm;
            end
            CMD_PO_WR: begin
                hp_we    = 1'b1;
                hp_wdata = last_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (h_we) hmem[lp_reg[CA_W-1:0]] <= h_wdata;
        h_rd_reg <= hmem[h_raddr];
    end

    always_ff @(posedge aclk) begin
        if (v_we) vmem[v_waddr] <= v_wdata;
        v_rd_reg <= vmem[na];
    end

    always_ff @(posedge aclk) begin
        if (hp_we) heap[hp_waddr] <= hp_wdata;
        rda_reg <= heap[hp_addr_a];
        rdb_reg <= heap[hp_addr_b];
    end

    // control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_reg    <= '0;
            count_reg <= '0;
            total_reg <= '0;
        end else begin
            unique case (cmd)
                CMD_LOAD: begin
                    if (in_last) begin
                        lp_reg    <= '0;
                        count_reg <= '0;
                        total_reg <= '0;
                    end else if (lp_reg < used) begin
                        lp_reg <= lp_reg + CN_W'(1);
                    end
                end
                CMD_PU_BEGIN: count_reg <= count_reg + HC_W'(1);
                CMD_PO_RD:    count_reg <= count_reg - HC_W'(1);
                CMD_NB_VISIT: begin
                    if (cur_lev > h_rd_reg)
                        total_reg <= total_reg + 32'(cur_lev - h_rd_reg);
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd)
            CMD_LOAD: begin
                cnt_reg   <= '0;
                sr_reg    <= '0;
                sc_reg    <= '0;
                saddr_reg <= '0;
            end
            CMD_CLR: cnt_reg <= cnt_reg + CA_W'(1);
            CMD_SEED_PUSH: item_reg <= {h_rd_reg, sr_reg, sc_reg};
            CMD_SEED_NX: begin
                if (sc_reg == cols_c - COL_W'(1)) begin
                    sr_reg    <= sr_reg + ROW_W'(1);
                    sc_reg    <= '0;
                    saddr_reg <= saddr_reg + CA_W'(1);
                end else if (sc_reg == '0 && sr_reg != '0
                             && sr_reg != rows_c - ROW_W'(1)) begin
                    // interior row: jump to the right border
                    sc_reg    <= cols_c - COL_W'(1);
                    saddr_reg <= saddr_reg + CA_W'(cols_c - COL_W'(1));
                end else begin
                    sc_reg    <= sc_reg + COL_W'(1);
                    saddr_reg <= saddr_reg + CA_W'(1);
                end
            end
            CMD_PU_BEGIN: i_reg <= count_reg[HA_W-1:0];
            CMD_PU_MOVE:  i_reg <= parent;
            CMD_PO_LAT: begin
                cur_reg  <= rda_reg;
                last_reg <= rdb_reg;
                i_reg    <= '0;
            end
            CMD_PO_MOVE: i_reg <= m_idx;
            CMD_NB_BASE: begin
                cur_addr_reg <= CA_W'(CN_W'(cur_row) * CN_W'(cols_c) + CN_W'(cur_col));
                dir_reg      <= DIR_UP;
            end
            CMD_NB_VISIT: begin
                if (cur_lev > h_rd_reg) item_reg <= {cur_lev, nrow, ncol};
                else item_reg <= {h_rd_reg, nrow, ncol};
            end
            CMD_NB_NX: dir_reg <= dir_reg + 2'd1;
            CMD_OUT:   out_reg <= total_reg;
            default: ;
        endcase
    end

    assign out_volume = out_reg;

    always_comb begin
        stat.clr_last   = CN_W'(cnt_reg) == used - CN_W'(1);
        stat.seed_last  = (sr_reg == rows_c - ROW_W'(1)) && (sc_reg == cols_c - COL_W'(1));
        stat.heap_full  = count_reg >= HC_W'(HDEPTH);
        stat.heap_empty = count_reg == '0;
        stat.pu_root    = i_reg == '0;
        stat.pu_stop    = rda_lev <= item_lev;
        stat.po_leaf    = lch >= HL_W'(count_reg);
        stat.po_stop    = hm_lev >= last_lev;
        stat.dir_ok     = dir_ok;
        stat.dir_last   = dir_reg == DIR_RIGHT;
        stat.nb_visited = v_rd_reg;
    end

endmodule

>>> hdl/pft_ctrl.sv
// controller: sequences loading, clearing, seeding, heap push/pop and neighbor visits
`timescale 1ns / 1ps
module pft_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_last,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  pft_pkg::stat_t stat,
    output pft_pkg::cmd_t  cmd
);
    import pft_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE     = 19'b0000000000000000001,
        S_CLR      = 19'b0000000000000000010,
        S_SEED_RD  = 19'b0000000000000000100,
        S_SEED_PU  = 19'b0000000000000001000,
        S_PU_BEGIN = 19'b0000000000000010000,
        S_PU_TEST  = 19'b0000000000000100000,
        S_PU_CMP   = 19'b0000000000001000000,
        S_PU_WR    = 19'b0000000000010000000,
        S_SEED_NX  = 19'b0000000000100000000,
        S_PO_RD    = 19'b0000000001000000000,
        S_PO_LAT   = 19'b0000000010000000000,
        S_PO_TEST  = 19'b0000000100000000000,
        S_PO_CMP   = 19'b0000001000000000000,
        S_PO_WR    = 19'b0000010000000000000,
        S_NB_BASE  = 19'b0000100000000000000,
        S_NB_SEL   = 19'b0001000000000000000,
        S_NB_CHK   = 19'b0010000000000000000,
        S_NB_NX    = 19'b0100000000000000000,
        S_DONE     = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ret_seed_reg, ret_seed_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        ret_seed_next = ret_seed_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = CMD_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd = CMD_LOAD;
                    if (s_last) state_next = S_CLR;
                end
            end
            S_CLR: begin
                cmd = CMD_CLR;
                if (stat.clr_last) state_next = S_SEED_RD;
            end
            S_SEED_RD: begin
                cmd        = CMD_SEED_RD;
                state_next = S_SEED_PU;
            end
            S_SEED_PU: begin
                cmd           = CMD_SEED_PUSH;
                ret_seed_next = 1'b1;
                state_next    = S_PU_BEGIN;
            end
            S_PU_BEGIN: begin
                if (stat.heap_full) begin
                    state_next = ret_seed_reg ? S_SEED_NX : S_NB_NX;
                end else begin
                    cmd        = CMD_PU_BEGIN;
                    state_next = S_PU_TEST;
                end
            end
            S_PU_TEST: begin
                if (stat.pu_root) begin
                    state_next = S_PU_WR;
                end else begin
                    cmd        = CMD_PU_RD;
                    state_next = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                if (stat.pu_stop) begin
                    state_next = S_PU_WR;
                end else begin
                    cmd        = CMD_PU_MOVE;
                    state_next = S_PU_TEST;
                end
            end
            S_PU_WR: begin
                cmd        = CMD_PU_WR;
                state_next = ret_seed_reg ? S_SEED_NX : S_NB_NX;
            end
            S_SEED_NX: begin
                cmd        = CMD_SEED_NX;
                state_next = stat.seed_last ? S_PO_RD : S_SEED_RD;
            end
            S_PO_RD: begin
                cmd        = CMD_PO_RD;
                state_next = S_PO_LAT;
            end
            S_PO_LAT: begin
                cmd        = CMD_PO_LAT;
                state_next = S_PO_TEST;
            end
            S_PO_TEST: begin
                if (stat.po_leaf) begin
                    state_next = S_PO_WR;
                end else begin
                    cmd        = CMD_PO_RD2;
                    state_next = S_PO_CMP;
                end
            end
            S_PO_CMP: begin
                if (stat.po_stop) begin
                    state_next = S_PO_WR;
                end else begin
                    cmd        = CMD_PO_MOVE;
                    state_next = S_PO_TEST;
                end
            end
            S_PO_WR: begin
                if (!stat.heap_empty) cmd = CMD_PO_WR;
                state_next = S_NB_BASE;
            end
            S_NB_BASE: begin
                cmd        = CMD_NB_BASE;
                state_next = S_NB_SEL;
            end
            S_NB_SEL: begin
                if (stat.dir_ok) begin
                    cmd        = CMD_NB_RD;
                    state_next = S_NB_CHK;
                end else begin
                    state_next = S_NB_NX;
                end
            end
            S_NB_CHK: begin
                if (stat.nb_visited) begin
                    state_next = S_NB_NX;
                end else begin
                    cmd           = CMD_NB_VISIT;
                    ret_seed_next = 1'b0;
                    state_next    = S_PU_BEGIN;
                end
            end
            S_NB_NX: begin
                cmd = CMD_NB_NX;
                if (!stat.dir_last) state_next = S_NB_SEL;
                else if (stat.heap_empty) state_next = S_DONE;
                else state_next = S_PO_RD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd          = CMD_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_seed_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_seed_reg <= ret_seed_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

>>> hdl/priority_flood_trapped_water_top.sv
// Loading writes the cells into the height store as they arrive. After the last cell a
// clearing pass runs over the rows*cols entries of the visited map. A push sifts the new
// item up a heap level at a time until it stops or reaches the root, then writes it; a border
// seed adds a height read before it. A pop takes the root, sifts the last item down until it
// stops or reaches a leaf, and pushes each unvisited in-bounds neighbor. Input is held off
// from the last cell until the result is in the output register; reset clears control state.
`timescale 1ns / 1ps
module priority_flood_trapped_water_top #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] height
    input  logic        s_axis_tlast,   // last_cell
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] trapped_volume
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import pft_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    pft_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_last  (s_axis_tlast),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pft_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_height  (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index[0]),
        .cfg_data   (cfg_data),
        .out_volume (m_axis_tdata)
    );

    // a last-cell transaction starts a flood, so input closes right after it
    a_flood_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after last cell");

    // a new result only comes out of a flood
    a_result_after_flood: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised without a flood");

endmodule
